>>> rtl/itt_pkg.sv
`default_nettype none

package itt_pkg;

  // Scanner mode, kept in one small register between bytes
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_IDENT   = 4'd1,
    MODE_DEC     = 4'd2,
    MODE_ZERO    = 4'd3,
    MODE_OCT     = 4'd4,
    MODE_HEXPFX  = 4'd5,
    MODE_HEX     = 4'd6,
    MODE_COMMENT = 4'd7,
    MODE_ESC     = 4'd8
  } mode_e;

  // Token kinds as reported on the result channel
  typedef enum logic [2:0] {
    KIND_IDENT    = 3'd0,
    KIND_DEC      = 3'd1,
    KIND_OCT      = 3'd2,
    KIND_HEX      = 3'd3,
    KIND_CHAR     = 3'd4,
    KIND_UNCLOSED = 3'd5,
    KIND_END      = 3'd6
  } kind_e;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned OutLineBits = 16;

  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChSeven  = 8'h37;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpperX = 8'h58;
  localparam logic [7:0] ChLowerX = 8'h78;
  localparam logic [7:0] ChNewln  = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    kind_e                  kind;
    logic [7:0]             char_code;
    logic [OutLineBits-1:0] line_number;
    logic                   last;
  } out_item_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_octd(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChSeven);
  endfunction

  function automatic logic is_hexd(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

endpackage

`default_nettype wire

>>> rtl/itt_scan.sv
`default_nettype none

// One scan step: next mode, newline count, and up to three token results
module itt_scan (
  input  itt_pkg::mode_e                      mode_i,
  input  itt_pkg::in_item_t                   item_i,
  input  logic [itt_pkg::OutLineBits-1:0]     line_i,
  output itt_pkg::mode_e                      mode_o,
  output logic                                line_inc_o,
  output logic [1:0]                          res_n_o,
  output itt_pkg::out_item_t                  res_o [itt_pkg::MaxResults]
);
  import itt_pkg::*;

  kind_e      kinds [MaxResults];
  logic [7:0] codes [MaxResults];
  logic [1:0] n;
  logic       start;
  logic [7:0] c;

  always_comb begin
    c          = item_i.byte_value;
    mode_o     = mode_i;
    line_inc_o = 1'b0;
    n          = 2'd0;
    start      = 1'b0;
    for (int i = 0; i < MaxResults; i++) begin
      kinds[i] = KIND_END;
      codes[i] = 8'h00;
    end

    if (item_i.end_of_input) begin
      // Flush any pending token, then the end or unclosed mark
      case (mode_i)
        MODE_IDENT: begin
          kinds[n] = KIND_IDENT; n = n + 2'd1;
        end
        MODE_DEC, MODE_ZERO: begin
          kinds[n] = KIND_DEC; n = n + 2'd1;
        end
        MODE_OCT: begin
          kinds[n] = KIND_OCT; n = n + 2'd1;
        end
        MODE_HEXPFX: begin
          kinds[n] = KIND_DEC; n = n + 2'd1;
          kinds[n] = KIND_IDENT; n = n + 2'd1;
        end
        MODE_HEX: begin
          kinds[n] = KIND_HEX; n = n + 2'd1;
        end
        default: ;
      endcase
      if ((mode_i == MODE_COMMENT) || (mode_i == MODE_ESC)) kinds[n] = KIND_UNCLOSED;
      else kinds[n] = KIND_END;
      n      = n + 2'd1;
      mode_o = MODE_IDLE;
    end else begin
      // Extend the current token, or close it and rescan the byte
      case (mode_i)
        MODE_IDENT: begin
          if (!is_alnum(c)) begin
            kinds[n] = KIND_IDENT; n = n + 2'd1; start = 1'b1;
          end
        end
        MODE_DEC: begin
          if (!is_digit(c)) begin
            kinds[n] = KIND_DEC; n = n + 2'd1; start = 1'b1;
          end
        end
        MODE_ZERO: begin
          if (is_octd(c)) mode_o = MODE_OCT;
          else if ((c == ChLowerX) || (c == ChUpperX)) mode_o = MODE_HEXPFX;
          else begin
            kinds[n] = KIND_DEC; n = n + 2'd1; start = 1'b1;
          end
        end
        MODE_OCT: begin
          if (!is_octd(c)) begin
            kinds[n] = KIND_OCT; n = n + 2'd1; start = 1'b1;
          end
        end
        MODE_HEXPFX: begin
          if (is_hexd(c)) mode_o = MODE_HEX;
          else begin
            // "0x" with no hex digit: decimal zero, then x starts an identifier
            kinds[n] = KIND_DEC; n = n + 2'd1;
            if (is_alnum(c)) mode_o = MODE_IDENT;
            else begin
              kinds[n] = KIND_IDENT; n = n + 2'd1; start = 1'b1;
            end
          end
        end
        MODE_HEX: begin
          if (!is_hexd(c)) begin
            kinds[n] = KIND_HEX; n = n + 2'd1; start = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (c == ChRbrace) mode_o = MODE_IDLE;
          else if (c == ChBslash) mode_o = MODE_ESC;
          else if (c == ChNewln) line_inc_o = 1'b1;
        end
        MODE_ESC: begin
          // escaped byte is skipped, newlines still count
          if (c == ChNewln) line_inc_o = 1'b1;
          mode_o = MODE_COMMENT;
        end
        default: start = 1'b1;
      endcase

      if (start) begin
        mode_o = MODE_IDLE;
        if (is_space(c)) begin
          if (c == ChNewln) line_inc_o = 1'b1;
        end else if (c == ChLbrace) mode_o = MODE_COMMENT;
        else if (is_alpha(c)) mode_o = MODE_IDENT;
        else if (c == ChZero) mode_o = MODE_ZERO;
        else if (is_digit(c)) mode_o = MODE_DEC;
        else begin
          kinds[n] = KIND_CHAR; codes[n] = c; n = n + 2'd1;
        end
      end
    end

    res_n_o = n;
    // All results of a step carry the line count from before the step
    for (int i = 0; i < MaxResults; i++) begin
      res_o[i].kind        = kinds[i];
      res_o[i].char_code   = codes[i];
      res_o[i].line_number = line_i;
      res_o[i].last        = (2'(i) == (n - 2'd1));
    end
  end

endmodule

`default_nettype wire

>>> rtl/itt_res_queue.sv
`default_nettype none

// Four-entry compacting result queue; head is always entry zero
module itt_res_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_n_i,
  input  itt_pkg::out_item_t  push_i [itt_pkg::MaxResults],
  input  logic                pop_i,
  output itt_pkg::out_item_t  head_o,
  output logic                valid_o,
  output logic [2:0]          count_o
);
  import itt_pkg::*;

  localparam int unsigned Depth = 4;

  out_item_t  slot_q [Depth];
  out_item_t  slot_d [Depth];
  logic [2:0] cnt_q, cnt_d;
  logic [2:0] base;
  logic [2:0] pos;
  logic [2:0] src;
  logic [2:0] rel;

  // Shift down on a pop, append new results behind the survivors
  always_comb begin
    base = cnt_q - {2'b00, pop_i};
    for (int i = 0; i < Depth; i++) begin
      pos = 3'(i);
      src = pos + {2'b00, pop_i};
      rel = pos - base;
      if (pos < base) slot_d[i] = slot_q[src[1:0]];
      else if (rel < {1'b0, push_n_i}) slot_d[i] = push_i[rel[1:0]];
      else slot_d[i] = slot_q[i];
    end
    cnt_d = base + {1'b0, push_n_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) slot_q[i] <= slot_d[i];
  end

  assign head_o  = slot_q[0];
  assign valid_o = (cnt_q != 3'd0);
  assign count_o = cnt_q;

endmodule

`default_nettype wire

>>> rtl/integer_identifier_tokenizer.sv
`default_nettype none

// Channel | Handshake              | Payload
// --------+------------------------+---------------------------------------
// input   | in_valid_i / in_ready_o | in_item_i  (byte_value, end_of_input)
// output  | out_valid_o / out_ready_i | out_item_o (kind, char_code,
//         |                        |   line_number, last)
//
// One byte is taken per cycle while in_ready_o is high; the mode and line
// registers update at the transfer and its 0..3 results enter a four-entry
// queue the same edge. The result port drains one entry per cycle while
// out_ready_i is high, one token per transfer, in the order they were queued.
// in_ready_o is high while at most one result is queued.
// Reset (rst_ni low, async) returns to idle between tokens, line 1, queue empty.
module integer_identifier_tokenizer #(
  parameter int unsigned LINE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  itt_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output itt_pkg::out_item_t out_item_o
);
  import itt_pkg::*;

  localparam int unsigned WideBits = (LINE_BITS > OutLineBits) ? LINE_BITS : OutLineBits;

  mode_e                  mode_q, mode_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [WideBits-1:0]    line_wide;
  logic [OutLineBits-1:0] line_shown;
  logic                   line_inc;
  logic [1:0]             res_n;
  out_item_t              res [MaxResults];
  logic                   in_xfer;
  logic                   out_xfer;
  logic [2:0]             q_count;

  assign in_ready_o = (q_count <= 3'd1);
  assign in_xfer    = in_valid_i && in_ready_o;

  // Clamp the line count to the width of the result field
  always_comb begin
    line_wide = WideBits'(line_q);
    if (line_wide > WideBits'({OutLineBits{1'b1}})) line_shown = '1;
    else line_shown = line_wide[OutLineBits-1:0];
  end

  itt_scan u_scan (
    .mode_i     (mode_q),
    .item_i     (in_item_i),
    .line_i     (line_shown),
    .mode_o     (mode_d),
    .line_inc_o (line_inc),
    .res_n_o    (res_n),
    .res_o      (res)
  );

  // Saturating line counter
  always_comb begin
    line_d = line_q;
    if (line_inc && (line_q != {LINE_BITS{1'b1}})) line_d = line_q + LINE_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      line_q <= LINE_BITS'(1);
    end else if (in_xfer) begin
      mode_q <= mode_d;
      line_q <= line_d;
    end
  end

  assign out_xfer = out_valid_o && out_ready_i;

  itt_res_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (in_xfer ? res_n : 2'd0),
    .push_i   (res),
    .pop_i    (out_xfer),
    .head_o   (out_item_o),
    .valid_o  (out_valid_o),
    .count_o  (q_count)
  );

endmodule

`default_nettype wire

>>> verif/tb_integer_identifier_tokenizer.sv
`default_nettype none

module tb_integer_identifier_tokenizer;
  import itt_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_item_o;

  integer_identifier_tokenizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o)
  );

  always #4 clk_i = ~clk_i;

  // Stimulus and expectation stores
  in_item_t  pending_bytes[$];
  out_item_t expected_tokens[$];
  out_item_t step_tokens[$];
  out_item_t want_tok;

  int unsigned send_idle_pct = 20;
  int unsigned recv_idle_pct = 75;
  int unsigned in_xfer_cnt = 0;
  int unsigned hold_cnt = 0;
  logic        hold_done = 1'b0;
  int          mismatch_cnt = 0;

  // Scanner shadow state
  mode_e       scan_st = MODE_IDLE;
  logic [15:0] line_ctr = 16'd1;

  // Character classes
  function automatic logic letter_ch(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic digit_ch(input logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic logic octal_ch(input logic [7:0] c);
    return c >= ChZero && c <= ChSeven;
  endfunction

  function automatic logic hex_ch(input logic [7:0] c);
    return digit_ch(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic blank_ch(input logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  // Token predictor
  function automatic void note_token(input kind_e k, input logic [7:0] ch);
    out_item_t r;
    r.kind        = k;
    r.char_code   = ch;
    r.line_number = line_ctr;
    r.last        = 1'b0;
    step_tokens.push_back(r);
  endfunction

  function automatic void bump_line();
    if (line_ctr != 16'hFFFF) line_ctr = line_ctr + 16'd1;
  endfunction

  function automatic void open_token(input logic [7:0] c);
    scan_st = MODE_IDLE;
    if (blank_ch(c)) begin
      if (c == ChNewln) bump_line();
    end else if (c == ChLbrace) begin
      scan_st = MODE_COMMENT;
    end else if (letter_ch(c)) begin
      scan_st = MODE_IDENT;
    end else if (c == ChZero) begin
      scan_st = MODE_ZERO;
    end else if (digit_ch(c)) begin
      scan_st = MODE_DEC;
    end else begin
      note_token(KIND_CHAR, c);
    end
  endfunction

  function automatic void scan_byte(input logic [7:0] c);
    logic restart;
    restart = 1'b1;
    case (scan_st)
      MODE_IDENT: begin
        if (letter_ch(c) || digit_ch(c)) restart = 1'b0;
        else note_token(KIND_IDENT, 8'h00);
      end
      MODE_DEC: begin
        if (digit_ch(c)) restart = 1'b0;
        else note_token(KIND_DEC, 8'h00);
      end
      MODE_ZERO: begin
        if (octal_ch(c)) begin
          scan_st = MODE_OCT;
          restart = 1'b0;
        end else if (c == ChLowerX || c == ChUpperX) begin
          scan_st = MODE_HEXPFX;
          restart = 1'b0;
        end else begin
          note_token(KIND_DEC, 8'h00);
        end
      end
      MODE_OCT: begin
        if (octal_ch(c)) restart = 1'b0;
        else note_token(KIND_OCT, 8'h00);
      end
      MODE_HEXPFX: begin
        if (hex_ch(c)) begin
          scan_st = MODE_HEX;
          restart = 1'b0;
        end else begin
          // the zero stands alone, the x opens an identifier
          note_token(KIND_DEC, 8'h00);
          if (letter_ch(c) || digit_ch(c)) begin
            scan_st = MODE_IDENT;
            restart = 1'b0;
          end else begin
            note_token(KIND_IDENT, 8'h00);
          end
        end
      end
      MODE_HEX: begin
        if (hex_ch(c)) restart = 1'b0;
        else note_token(KIND_HEX, 8'h00);
      end
      MODE_COMMENT: begin
        restart = 1'b0;
        if (c == ChRbrace) scan_st = MODE_IDLE;
        else if (c == ChBslash) scan_st = MODE_ESC;
        else if (c == ChNewln) bump_line();
      end
      MODE_ESC: begin
        restart = 1'b0;
        if (c == ChNewln) bump_line();
        scan_st = MODE_COMMENT;
      end
      default: ;
    endcase
    if (restart) open_token(c);
  endfunction

  function automatic void scan_end();
    case (scan_st)
      MODE_IDENT:          note_token(KIND_IDENT, 8'h00);
      MODE_DEC, MODE_ZERO: note_token(KIND_DEC, 8'h00);
      MODE_OCT:            note_token(KIND_OCT, 8'h00);
      MODE_HEXPFX: begin
        note_token(KIND_DEC, 8'h00);
        note_token(KIND_IDENT, 8'h00);
      end
      MODE_HEX:            note_token(KIND_HEX, 8'h00);
      default: ;
    endcase
    if (scan_st == MODE_COMMENT || scan_st == MODE_ESC) note_token(KIND_UNCLOSED, 8'h00);
    else note_token(KIND_END, 8'h00);
    scan_st = MODE_IDLE;
  endfunction

  // Driver: offers the next pending byte, holds it until the transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else if (!in_valid || in_ready_o) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item  <= pending_bytes.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, once, early in the run
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && in_xfer_cnt >= 60) begin
      hold_cnt  <= 400;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Receiver ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on each input transfer, checks each result transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        step_tokens.delete();
        if (in_item.end_of_input) scan_end();
        else scan_byte(in_item.byte_value);
        if (step_tokens.size() != 0) begin
          want_tok = step_tokens.pop_back();
          want_tok.last = 1'b1;
          step_tokens.push_back(want_tok);
        end
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
        in_xfer_cnt <= in_xfer_cnt + 1;
      end
      if (out_valid_o && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected token: kind %0d line %0d", out_item_o.kind,
                 out_item_o.line_number);
          mismatch_cnt++;
        end else begin
          want_tok = expected_tokens.pop_front();
          if (out_item_o.kind !== want_tok.kind) begin
            $error("kind: expected %0d, got %0d", want_tok.kind, out_item_o.kind);
            mismatch_cnt++;
          end
          if (out_item_o.char_code !== want_tok.char_code) begin
            $error("char_code: expected %0d, got %0d", want_tok.char_code,
                   out_item_o.char_code);
            mismatch_cnt++;
          end
          if (out_item_o.line_number !== want_tok.line_number) begin
            $error("line_number: expected %0d, got %0d", want_tok.line_number,
                   out_item_o.line_number);
            mismatch_cnt++;
          end
          if (out_item_o.last !== want_tok.last) begin
            $error("last: expected %0d, got %0d", want_tok.last, out_item_o.last);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // Stimulus helpers
  task automatic push_byte(input logic [7:0] b);
    in_item_t it;
    it.byte_value   = b;
    it.end_of_input = 1'b0;
    pending_bytes.push_back(it);
  endtask

  task automatic push_end();
    in_item_t it;
    it.byte_value   = 8'($urandom_range(255));
    it.end_of_input = 1'b1;
    pending_bytes.push_back(it);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] rnd_letter();
    if ($urandom_range(1)) return 8'h41 + 8'($urandom_range(25));
    return 8'h61 + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rnd_digit(input int unsigned top);
    return ChZero + 8'($urandom_range(top));
  endfunction

  function automatic logic [7:0] rnd_hex();
    case ($urandom_range(2))
      0:       return rnd_digit(9);
      1:       return 8'h41 + 8'($urandom_range(5));
      default: return 8'h61 + 8'($urandom_range(5));
    endcase
  endfunction

  function automatic logic [7:0] rnd_blank();
    case ($urandom_range(5))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChNewln;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return ChCr;
    endcase
  endfunction

  // Mostly well-formed tokens with random content, some noise and end marks
  task automatic add_random_token();
    int unsigned n;
    case ($urandom_range(11))
      0, 1: begin
        push_byte(rnd_letter());
        n = $urandom_range(4);
        repeat (n) push_byte($urandom_range(1) ? rnd_letter() : rnd_digit(9));
      end
      2: begin
        push_byte(ChZero + 8'($urandom_range(8, 1)));
        n = $urandom_range(3);
        repeat (n) push_byte(rnd_digit(9));
      end
      3: begin
        push_byte(ChZero);
        n = $urandom_range(3, 1);
        repeat (n) push_byte(rnd_digit(7));
      end
      4: begin
        push_byte(ChZero);
        push_byte($urandom_range(1) ? ChLowerX : ChUpperX);
        n = $urandom_range(3, 1);
        repeat (n) push_byte(rnd_hex());
      end
      5: push_byte(ChZero);
      6: begin
        push_byte(ChLbrace);
        n = $urandom_range(6);
        repeat (n) begin
          case ($urandom_range(3))
            0: push_byte(rnd_letter());
            1: push_byte(ChNewln);
            2: begin
              push_byte(ChBslash);
              case ($urandom_range(2))
                0:       push_byte(ChRbrace);
                1:       push_byte(ChNewln);
                default: push_byte(8'($urandom_range(255)));
              endcase
            end
            default: push_byte(8'($urandom_range(255)));
          endcase
        end
        // occasionally left open so later text lands in the comment
        if ($urandom_range(9) != 0) push_byte(ChRbrace);
      end
      7: begin
        n = $urandom_range(3, 1);
        repeat (n) push_byte(rnd_blank());
      end
      8: push_byte(8'($urandom_range(255)));
      9: begin
        push_byte(ChZero);
        push_byte($urandom_range(1) ? ChLowerX : ChUpperX);
        push_byte($urandom_range(1) ? (8'h67 + 8'($urandom_range(19))) :
                                      8'($urandom_range(47)));
      end
      10: begin
        n = $urandom_range(3, 1);
        repeat (n) push_byte(8'($urandom_range(255)));
      end
      default: begin
        if ($urandom_range(2) == 0) push_end();
        else push_byte(rnd_blank());
      end
    endcase
    if ($urandom_range(1)) push_byte(rnd_blank());
  endtask

  task automatic add_random_items(input int unsigned count);
    int unsigned goal;
    goal = pending_bytes.size() + count;
    while (pending_bytes.size() < goal) add_random_token();
  endtask

  task automatic drain_pending();
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Sequence: reset, directed, three phases with different idle rates
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_text("Z9 ");
    push_text("07\n");
    push_text("0Xf;");
    push_text("09");
    push_text("0xg}");
    push_text("0x");
    push_byte(8'hFF);
    push_text("{\\\n}");
    push_byte(8'h00);
    push_byte(8'h80);
    push_text("0x");
    push_end();
    push_byte(ChLbrace);
    push_end();
    add_random_items(120);
    drain_pending();

    send_idle_pct = 75;
    recv_idle_pct = 20;
    add_random_items(120);
    drain_pending();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_items(120);
    push_text("q7\n0x1 ");
    push_end();
    drain_pending();

    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (expected_tokens.size() != 0) begin
      $error("%0d expected tokens never arrived", expected_tokens.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("** integer_identifier_tokenizer: PASSED **");
    end else begin
      $display("** integer_identifier_tokenizer: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(8 * 600000);
    $display("** integer_identifier_tokenizer: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
